// ----- src/iqenv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iqenv_pkg
// shared widths and helpers for the iq envelope demodulator
// ----------------------------------------------------------------------------
package iqenv_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_FRAC_BITS = 16;
   localparam int COEF_BITS      = COEF_FRAC_BITS + 4;
   localparam int ACC_BITS       = SAMPLE_BITS + 8;
   localparam int MAG_BITS       = SAMPLE_BITS + 2;
   localparam int RESULT_BITS    = 20;
   localparam int NUM_REGS       = 5;
   localparam int CSR_IDX_BITS   = 3;
   localparam int PROD_BITS      = COEF_BITS + ACC_BITS;
   localparam int SUM_BITS       = PROD_BITS + 3;
   localparam int SQ_BITS        = 2 * ACC_BITS + 1;
   localparam int POLE_NUM       = 65208;
   localparam int POLE_FRAC      = 16;
   localparam int ISQRT_STEPS    = SQ_BITS / 2 + 1;
   localparam int ISQRT_CNT_BITS = $clog2(ISQRT_STEPS + 1);

   localparam logic [CSR_IDX_BITS-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_A1 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_A2 = 3'd4;

   typedef logic signed [COEF_BITS-1:0] coef_type;
   typedef logic signed [ACC_BITS-1:0]  acc_type;

   // handshake between sequencer and isqrt unit
   typedef struct packed {
      logic                  start;
      logic [SQ_BITS-1:0]    radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic                  done;
      logic [MAG_BITS-2:0]   root;
   } sqrt_rsp_type;

endpackage
`default_nettype wire

// ----- src/iqenv_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iqenv_isqrt
// bit-serial integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module iqenv_isqrt (
   input  wire                     clock,
   input  wire                     reset,
   input  iqenv_pkg::sqrt_req_type req,
   output iqenv_pkg::sqrt_rsp_type rsp
);
   import iqenv_pkg::*;

   localparam int W = 2 * ISQRT_STEPS;

   logic [W-1:0]              rem_ff, rem_in;
   logic [W-1:0]              res_ff, res_in;
   logic [W-1:0]              bit_ff, bit_in;
   logic [ISQRT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [W-1:0]              trial;
   logic [W-ISQRT_STEPS-1:0]  unused_hi;

   assign trial = res_ff + bit_ff;
   assign unused_hi = res_ff[W-1:ISQRT_STEPS];

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = W'(req.radicand);
         res_in  = '0;
         bit_in  = {2'b01, {(W-2){1'b0}}};
         cnt_in  = ISQRT_CNT_BITS'(ISQRT_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ISQRT_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   // root fits in ISQRT_STEPS bits; saturate to the magnitude range
   always_comb begin
      rsp.done = done_ff;
      if ((|unused_hi) || (res_ff[ISQRT_STEPS-1:0] > ISQRT_STEPS'((1 << (MAG_BITS-1)) - 1)))
         rsp.root = '1;
      else
         rsp.root = res_ff[MAG_BITS-2:0];
   end

endmodule
`default_nettype wire

// ----- src/iq_envelope_demodulator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iq_envelope_demodulator_top
// iq biquad filter, magnitude, dc blocker, one result per sample
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  req     | req_valid/stall, i/q_sample    | in, one iq sample
//  rsp     | rsp_valid/stall, envelope_ac   | out, one envelope value
//  csr     | csr_valid/ready, index, wdata  | in, coefficient write
//
//  a sample is taken only in idle; it then runs through these steps in order:
//  ten multiply-accumulate steps on one shared multiplier, the two squares,
//  a 25 step bit-serial square root with the dc blocker multiply overlapped
//  on the shared multiplier, the load of the output register and the
//  return to idle
//  reset clears all filter state and loads b0 = 1.0, others zero
//  the result sits in an output register; the next sample is taken while
//  it waits, but a third waits until the register is free
// ----------------------------------------------------------------------------
module iq_envelope_demodulator_top (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  wire  signed [iqenv_pkg::SAMPLE_BITS-1:0]  req_i_sample,
   input  wire  signed [iqenv_pkg::SAMPLE_BITS-1:0]  req_q_sample,
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output logic signed [iqenv_pkg::RESULT_BITS-1:0]  rsp_envelope_ac,
   input  wire                                       csr_valid,
   output logic                                      csr_ready,
   input  wire         [iqenv_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire         [iqenv_pkg::COEF_BITS-1:0]    csr_wdata
);
   import iqenv_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MAC  = 7'b0000010,
      ST_SAT  = 7'b0000100,
      ST_SQ   = 7'b0001000,
      ST_ROOT = 7'b0010000,
      ST_DC   = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   coef_type coef_ff [NUM_REGS];

   acc_type  xi_ff [2];
   acc_type  xq_ff [2];
   acc_type  yi_ff [2];
   acc_type  yq_ff [2];
   logic [MAG_BITS-1:0] dc_in_ff;
   acc_type  dc_out_ff;

   acc_type  cur_i_ff, cur_q_ff;
   logic signed [SUM_BITS-1:0] acc_ff;
   logic [SQ_BITS-1:0]         sq_ff;
   logic [3:0]                 step_ff;
   logic                       res_valid_ff;
   logic signed [RESULT_BITS-1:0] res_ff;

   // shared multiplier
   logic signed [COEF_BITS-1:0] mul_a;
   logic signed [ACC_BITS-1:0]  mul_b;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic                        prod_en_ff;
   logic                        prod_neg_ff;

   sqrt_req_type sreq;
   sqrt_rsp_type srsp;

   logic accept;
   logic signed [SUM_BITS-1:0] rnd;
   acc_type biq_y;
   logic signed [SUM_BITS-1:0] dc_sum;
   acc_type dc_y;

   iqenv_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .req   (sreq),
      .rsp   (srsp)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = res_valid_ff;
   assign rsp_envelope_ac = res_ff;

   // step schedule: 0..4 i-channel taps, 5..9 q-channel taps
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         4'd0: begin mul_a = coef_ff[0]; mul_b = cur_i_ff;  end
         4'd1: begin mul_a = coef_ff[1]; mul_b = xi_ff[0];  end
         4'd2: begin mul_a = coef_ff[2]; mul_b = xi_ff[1];  end
         4'd3: begin mul_a = coef_ff[3]; mul_b = yi_ff[0];  end
         4'd4: begin mul_a = coef_ff[4]; mul_b = yi_ff[1];  end
         4'd5: begin mul_a = coef_ff[0]; mul_b = cur_q_ff;  end
         4'd6: begin mul_a = coef_ff[1]; mul_b = xq_ff[0];  end
         4'd7: begin mul_a = coef_ff[2]; mul_b = xq_ff[1];  end
         4'd8: begin mul_a = coef_ff[3]; mul_b = yq_ff[0];  end
         4'd9: begin mul_a = coef_ff[4]; mul_b = yq_ff[1];  end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      // dc blocker feedback product while the root is running
      if (state_ff == ST_ROOT) begin
         mul_a = COEF_BITS'(POLE_NUM);
         mul_b = dc_out_ff;
      end
   end

   assign prod = mul_a * mul_b;

   // round half up then floor shift, saturate to accumulator width
   always_comb begin
      rnd = (acc_ff + SUM_BITS'(1 << (COEF_FRAC_BITS-1))) >>> COEF_FRAC_BITS;
      if (rnd > SUM_BITS'((1 << (ACC_BITS-1)) - 1))
         biq_y = {1'b0, {(ACC_BITS-1){1'b1}}};
      else if (rnd < -SUM_BITS'(1 << (ACC_BITS-1)))
         biq_y = {1'b1, {(ACC_BITS-1){1'b0}}};
      else
         biq_y = rnd[ACC_BITS-1:0];
   end

   // dc blocker: x - x_prev + round(pole * y_prev)
   always_comb begin
      dc_sum = SUM_BITS'($signed({1'b0, srsp.root})) - SUM_BITS'($signed({1'b0, dc_in_ff}))
             + ((SUM_BITS'(prod_ff) + SUM_BITS'(1 << (POLE_FRAC-1))) >>> POLE_FRAC);
      if (dc_sum > SUM_BITS'((1 << (ACC_BITS-1)) - 1))
         dc_y = {1'b0, {(ACC_BITS-1){1'b1}}};
      else if (dc_sum < -SUM_BITS'(1 << (ACC_BITS-1)))
         dc_y = {1'b1, {(ACC_BITS-1){1'b0}}};
      else
         dc_y = dc_sum[ACC_BITS-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_MAC;
         ST_MAC:  if (!prod_en_ff && step_ff == 4'd10) state_in = ST_SQ;
         ST_SAT:  state_in = ST_SQ;
         ST_SQ:   if (step_ff == 4'd2) state_in = ST_ROOT;
         ST_ROOT: if (srsp.done) state_in = ST_OUT;
         ST_DC:   state_in = ST_OUT;
         ST_OUT:  if (!res_valid_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      sreq.start    = (state_ff == ST_SQ) && (step_ff == 4'd2);
      sreq.radicand = sq_ff;
   end

   logic [ACC_BITS-1:0] abs_i, abs_q, abs_sel;
   logic [2*ACC_BITS-1:0] sq_prod;
   assign abs_i   = yi_ff[0][ACC_BITS-1] ? ACC_BITS'(-yi_ff[0]) : yi_ff[0];
   assign abs_q   = yq_ff[0][ACC_BITS-1] ? ACC_BITS'(-yq_ff[0]) : yq_ff[0];
   assign abs_sel = (step_ff == 4'd0) ? abs_i : abs_q;
   assign sq_prod = abs_sel * abs_sel;

   logic pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_valid_ff <= 1'b0;
         step_ff      <= '0;
         prod_en_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         coef_ff[0]   <= COEF_BITS'(1 << COEF_FRAC_BITS);
         for (int k = 1; k < NUM_REGS; k++) coef_ff[k] <= '0;
         for (int k = 0; k < 2; k++) begin
            xi_ff[k] <= '0; xq_ff[k] <= '0; yi_ff[k] <= '0; yq_ff[k] <= '0;
         end
         dc_in_ff  <= '0;
         dc_out_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready && csr_index < CSR_IDX_BITS'(NUM_REGS))
            coef_ff[csr_index] <= csr_wdata;
         if (res_valid_ff && !rsp_stall) res_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cur_i_ff   <= ACC_BITS'(req_i_sample);
                  cur_q_ff   <= ACC_BITS'(req_q_sample);
                  step_ff    <= '0;
                  acc_ff     <= '0;
                  prod_en_ff <= 1'b0;
               end
            end
            ST_MAC: begin
               // multiply registered, accumulated in the following cycle
               if (step_ff == 4'd6 && pend_ff) begin
                  // acc_ff holds the i taps; restart with the first q product
                  yi_ff[1] <= yi_ff[0];
                  yi_ff[0] <= biq_y;
                  xi_ff[1] <= xi_ff[0];
                  xi_ff[0] <= cur_i_ff;
                  acc_ff   <= prod_neg_ff ? -SUM_BITS'(prod_ff) : SUM_BITS'(prod_ff);
               end else if (prod_en_ff) begin
                  acc_ff <= prod_neg_ff ? acc_ff - SUM_BITS'(prod_ff)
                                        : acc_ff + SUM_BITS'(prod_ff);
               end
               if (step_ff != 4'd10) begin
                  prod_ff     <= prod;
                  prod_neg_ff <= (step_ff == 4'd3) || (step_ff == 4'd4) ||
                                 (step_ff == 4'd8) || (step_ff == 4'd9);
                  prod_en_ff  <= 1'b1;
                  step_ff     <= step_ff + 1'b1;
               end else begin
                  prod_en_ff <= 1'b0;
               end
               // i-channel sum complete once tap 4 is accumulated
               if (prod_en_ff && step_ff == 4'd5 && !pend_ff) begin
                  pend_ff <= 1'b1;
               end
               if (pend_ff && step_ff == 4'd6) begin
                  pend_ff <= 1'b0;
               end
               if (!prod_en_ff && step_ff == 4'd10) begin
                  yq_ff[1] <= yq_ff[0];
                  yq_ff[0] <= biq_y;
                  xq_ff[1] <= xq_ff[0];
                  xq_ff[0] <= cur_q_ff;
                  step_ff  <= '0;
               end
            end
            ST_SAT: step_ff <= '0;
            ST_SQ: begin
               if (step_ff == 4'd0) sq_ff <= SQ_BITS'(sq_prod);
               else if (step_ff == 4'd1) sq_ff <= sq_ff + SQ_BITS'(sq_prod);
               step_ff <= step_ff + 1'b1;
            end
            ST_ROOT: begin
               prod_ff <= prod;
               if (srsp.done) begin
                  dc_in_ff  <= {1'b0, srsp.root};
                  dc_out_ff <= dc_y;
               end
            end
            ST_DC: step_ff <= '0;
            ST_OUT: begin
               // load the output register once it is free
               if (!res_valid_ff) begin
                  res_valid_ff <= 1'b1;
                  if (dc_out_ff > ACC_BITS'((1 << (RESULT_BITS-1)) - 1))
                     res_ff <= {1'b0, {(RESULT_BITS-1){1'b1}}};
                  else if (dc_out_ff < -ACC_BITS'(1 << (RESULT_BITS-1)))
                     res_ff <= {1'b1, {(RESULT_BITS-1){1'b0}}};
                  else
                     res_ff <= dc_out_ff[RESULT_BITS-1:0];
               end
               step_ff <= '0;
            end
            default: step_ff <= '0;
         endcase
      end
   end

endmodule
`default_nettype wire
